>>> hw/rtl/dsht_pkg.sv
`timescale 1ns / 1ps
// Package for the dense slot handle table: sizes, codes, payload structs and
// the sequencer state type. No dependencies.
`default_nettype none

package dsht_pkg;

    // Table size; a power of two so that handles and slots wrap in their own bits.
    localparam int MAX_ELEMENTS = 256;
    localparam int SLOT_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = SLOT_W + 1;

    // Field widths of the payloads.
    localparam int ACTION_W = 2;
    localparam int HANDLE_W = 8;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 15;

    // Configuration port.
    localparam int CFG_W       = 7;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTICES = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDICES  = 1'd1;
    localparam logic [CFG_W-1:0] VERTICES_RESET = 7'd4;
    localparam logic [CFG_W-1:0] INDICES_RESET  = 7'd6;

    // Action codes; the unused code behaves as a query.
    localparam logic [ACTION_W-1:0] ACT_CREATE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DESTROY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [HANDLE_W-1:0] handle;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] result_handle;
        logic [SLOT_W-1:0]   location;
        logic                is_valid;
        logic                move_needed;
        logic [SLOT_W-1:0]   move_from;
        logic [SLOT_W-1:0]   move_to;
        logic [CNT_W-1:0]    element_count;
        logic [TOTAL_W-1:0]  vertex_total;
        logic [TOTAL_W-1:0]  index_total;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_SCALE_V,
        S_SCALE_I
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/dsht_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response streams.
// Depends on dsht_pkg for the payload structs.
`default_nettype none

interface dsht_req_if;
    import dsht_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dsht_rsp_if;
    import dsht_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dsht_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dsht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/dense_slot_handle_table_top.sv
`timescale 1ns / 1ps
// Dense slot handle table: handle/slot maps, free-handle FIFO and totals.
// Depends on dsht_pkg, dsht_req_if, dsht_rsp_if and dsht_ram.
`default_nettype none

//  port        dir  transfer carries
//  i_req_if    in   action, handle
//  o_rsp_if    out  status, handles, slots, move, element/vertex/index totals
//  i_cfg_*     in   write of vertices (index 0) or indices (index 1) per element
//
//  An operation walks five steps, and a new request is not taken until the
//  last is through them: the idle step that takes the transfer, one for the
//  map and FIFO reads, one to update the maps, and two on the shared
//  multiplier for the vertex and index totals. The last step loads the result.
//  Ready is high only in the idle state. The result sits in an output
//  register, so the next request is taken while a result is still waiting;
//  a stalled response holds the sequencer in its last step.
//  Reset is synchronous and active low; the maps and FIFO need no clearing,
//  since live bits in flip-flops guard every map access.

module dense_slot_handle_table_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [dsht_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [dsht_pkg::CFG_W-1:0]   i_cfg_data,
    dsht_req_if.sink                          i_req_if,
    dsht_rsp_if.source                        o_rsp_if
);
    import dsht_pkg::*;

    localparam int PROD_W = CNT_W + CFG_W;

    // Sequencer and request.
    t_state r_state, n_state;
    t_req   r_req, n_req;

    // Table state.
    logic [MAX_ELEMENTS-1:0] r_live, n_live;
    logic [SLOT_W-1:0]       r_free_head, n_free_head;
    logic [CNT_W-1:0]        r_free_count, n_free_count;
    logic [CNT_W-1:0]        r_issued, n_issued;
    logic [CNT_W-1:0]        r_count, n_count;

    // Configuration.
    logic [CFG_W-1:0] r_vpe, r_ipe;

    // Result being built and the output register.
    t_rsp r_res, n_res;
    t_rsp r_out, n_out;
    logic r_out_valid, n_out_valid;

    // Memory ports.
    logic              h2s_we, s2h_we, fifo_we;
    logic [SLOT_W-1:0] h2s_waddr, h2s_wdata, h2s_rdata;
    logic [SLOT_W-1:0] s2h_waddr, s2h_wdata, s2h_rdata;
    logic [SLOT_W-1:0] fifo_waddr, fifo_wdata, fifo_rdata;
    logic [SLOT_W-1:0] last_slot;
    logic [CNT_W-1:0]  fifo_tail;

    // Shared multiplier.
    logic [CFG_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;

    logic accept, out_free, live_hit;
    logic [SLOT_W-1:0] new_handle;

    assign accept    = i_req_if.valid && i_req_if.ready;
    assign out_free  = !r_out_valid || o_rsp_if.ready;
    assign last_slot = SLOT_W'(r_count - CNT_W'(1));
    assign fifo_tail = CNT_W'(r_free_head) + r_free_count;
    assign live_hit  = r_live[r_req.handle[SLOT_W-1:0]];
    assign new_handle = (r_free_count != '0) ? fifo_rdata : r_issued[SLOT_W-1:0];

    assign mul_b = (r_state == S_SCALE_V) ? r_vpe : r_ipe;
    assign prod  = PROD_W'(r_res.element_count) * PROD_W'(mul_b);

    assign i_req_if.ready = (r_state == S_IDLE);
    assign o_rsp_if.valid = r_out_valid;
    assign o_rsp_if.data  = r_out;

    // handle -> slot, slot -> handle and the free-handle FIFO.
    dsht_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ELEMENTS)) u_h2s (
        .i_clk   (i_clk),
        .i_we    (h2s_we),
        .i_waddr (h2s_waddr),
        .i_wdata (h2s_wdata),
        .i_raddr (r_req.handle[SLOT_W-1:0]),
        .o_rdata (h2s_rdata)
    );

    dsht_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ELEMENTS)) u_s2h (
        .i_clk   (i_clk),
        .i_we    (s2h_we),
        .i_waddr (s2h_waddr),
        .i_wdata (s2h_wdata),
        .i_raddr (last_slot),
        .o_rdata (s2h_rdata)
    );

    dsht_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ELEMENTS)) u_fifo (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (fifo_waddr),
        .i_wdata (fifo_wdata),
        .i_raddr (r_free_head),
        .o_rdata (fifo_rdata)
    );

    // Next state: a fixed walk through the steps, held at the end on a stall.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (accept) n_state = S_READ;
            S_READ:    n_state = S_UPDATE;
            S_UPDATE:  n_state = S_SCALE_V;
            S_SCALE_V: n_state = S_SCALE_I;
            S_SCALE_I: if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath control for each step.
    always_comb begin
        n_req        = r_req;
        n_live       = r_live;
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        n_issued     = r_issued;
        n_count      = r_count;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        h2s_we       = 1'b0;
        s2h_we       = 1'b0;
        fifo_we      = 1'b0;
        h2s_waddr    = '0;
        h2s_wdata    = '0;
        s2h_waddr    = '0;
        s2h_wdata    = '0;
        fifo_waddr   = fifo_tail[SLOT_W-1:0];
        fifo_wdata   = r_req.handle[SLOT_W-1:0];

        // Drop the result once the sink has taken it.
        if (r_out_valid && o_rsp_if.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req = i_req_if.data;
                end
            end
            S_UPDATE: begin
                n_res               = '0;
                n_res.result_handle = r_req.handle;
                case (r_req.action)
                    ACT_CREATE: begin
                        n_res.result_handle = '0;
                        if (r_count[CNT_W-1]) begin
                            n_res.status = STATUS_FULL;
                        end else begin
                            // Place the handle at the end of the packed slots.
                            h2s_we    = 1'b1;
                            h2s_waddr = new_handle;
                            h2s_wdata = r_count[SLOT_W-1:0];
                            s2h_we    = 1'b1;
                            s2h_waddr = r_count[SLOT_W-1:0];
                            s2h_wdata = new_handle;
                            n_live[new_handle] = 1'b1;
                            if (r_free_count != '0) begin
                                n_free_head  = r_free_head + SLOT_W'(1);
                                n_free_count = r_free_count - CNT_W'(1);
                            end else begin
                                n_issued = r_issued + CNT_W'(1);
                            end
                            n_count             = r_count + CNT_W'(1);
                            n_res.result_handle = HANDLE_W'(new_handle);
                            n_res.location      = r_count[SLOT_W-1:0];
                            n_res.is_valid      = 1'b1;
                        end
                    end
                    ACT_DESTROY: begin
                        if (!live_hit) begin
                            n_res.status = STATUS_INVALID;
                        end else begin
                            // Move the last element into the freed slot.
                            h2s_we    = 1'b1;
                            h2s_waddr = s2h_rdata;
                            h2s_wdata = h2s_rdata;
                            s2h_we    = 1'b1;
                            s2h_waddr = h2s_rdata;
                            s2h_wdata = s2h_rdata;
                            fifo_we   = 1'b1;
                            n_free_count = r_free_count + CNT_W'(1);
                            n_live[r_req.handle[SLOT_W-1:0]] = 1'b0;
                            n_count        = r_count - CNT_W'(1);
                            n_res.location = h2s_rdata;
                            if (h2s_rdata != last_slot) begin
                                n_res.move_needed = 1'b1;
                                n_res.move_from   = last_slot;
                                n_res.move_to     = h2s_rdata;
                            end
                        end
                    end
                    default: begin
                        if (live_hit) begin
                            n_res.location = h2s_rdata;
                            n_res.is_valid = 1'b1;
                        end else begin
                            n_res.status = STATUS_INVALID;
                        end
                    end
                endcase
                n_res.element_count = n_count;
            end
            S_SCALE_V: begin
                n_res.vertex_total = prod[TOTAL_W-1:0];
            end
            S_SCALE_I: begin
                if (out_free) begin
                    n_out             = r_res;
                    n_out.index_total = prod[TOTAL_W-1:0];
                    n_out_valid       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_live       <= '0;
            r_free_head  <= '0;
            r_free_count <= '0;
            r_issued     <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_vpe        <= VERTICES_RESET;
            r_ipe        <= INDICES_RESET;
        end else begin
            r_state      <= n_state;
            r_live       <= n_live;
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            r_issued     <= n_issued;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VERTICES: r_vpe <= i_cfg_data;
                    CFG_INDICES:  r_ipe <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

>>> hw/rtl/dsht_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the dense slot handle table, bound to the top level.
// Depends on dsht_pkg.
`default_nettype none

module dsht_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_req_valid,
    input wire logic          i_req_ready,
    input wire logic          i_rsp_valid,
    input wire logic          i_rsp_ready,
    input wire dsht_pkg::t_rsp i_rsp
);
    import dsht_pkg::*;

    // A waiting response holds its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("response dropped or changed while stalled");

    // One operation at a time: ready falls after a transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while an operation is in progress");

    // A failed operation reports no slot and no move.
    a_fail_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.status != STATUS_OK |->
            !i_rsp.move_needed && !i_rsp.is_valid && i_rsp.location == '0)
        else $error("failed operation reports a slot or move");

    // A move always goes between two different slots.
    a_move_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.move_needed |-> i_rsp.move_from != i_rsp.move_to)
        else $error("move between equal slots");

    // Full is only reported with the table at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.status == STATUS_FULL |->
            i_rsp.element_count == CNT_W'(MAX_ELEMENTS))
        else $error("table full reported below capacity");

endmodule

bind dense_slot_handle_table_top dsht_checker u_dsht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_if.valid),
    .i_req_ready (i_req_if.ready),
    .i_rsp_valid (o_rsp_if.valid),
    .i_rsp_ready (o_rsp_if.ready),
    .i_rsp       (o_rsp_if.data)
);

`default_nettype wire
